FILE: hw/rtl/wst_pkg.sv
// shared types and constants for the window stack hit test block
`timescale 1ns / 1ps
`default_nettype none

package wst_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_LOAD
  } cell_op_t;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_CLOSE  = 3'd1;
  localparam logic [2:0] ACT_RAISE  = 3'd2;
  localparam logic [2:0] ACT_CLICK  = 3'd3;
  localparam logic [2:0] ACT_HIT    = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_SLOT = 2'd2;
  localparam logic [1:0] STAT_MISS     = 2'd3;

  // close button span on the title row: right edge minus 4 up to right edge minus 2
  localparam logic [7:0]         CLOSE_MIN_WIDTH = 8'd5;
  localparam logic signed [11:0] CLOSE_LO_OFS    = 12'sd4;
  localparam logic signed [11:0] CLOSE_HI_OFS    = 12'sd2;

  typedef struct packed {
    logic signed [9:0] left;
    logic signed [9:0] top;
    logic [7:0]        width;
    logic [7:0]        height;
  } rect_t;

  typedef struct packed {
    cell_op_t op;
    logic     eval;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic hit;
    logic close_hit;
  } cell_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/window_stack_hit_test.sv
// window stack with hit test: top level, sequencer and chain of list cells
// an input beat passes the capture, evaluate, apply and report steps before its result beat
// one item at a time: the sequencer walks its four steps, report waiting for a free output register
// a new item is taken while the previous result waits in the output register
// reset (rst_n low, synchronous) empties the list; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module window_stack_hit_test #(
  parameter int MAX_WINDOWS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_action,
  input  logic [2:0]        in_slot,
  input  logic signed [9:0] in_pos_col,
  input  logic signed [9:0] in_pos_row,
  input  logic [7:0]        in_width,
  input  logic [7:0]        in_height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [2:0]        out_result_slot,
  output logic              out_was_closed,
  output logic              out_focus_valid,
  output logic [2:0]        out_focus_slot,
  output logic [3:0]        out_open_count
);
  import wst_pkg::*;

  localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WINDOWS);

  state_t state_r, state_nxt;
  logic   eval_en, apply_en, report_en, out_free;

  logic [2:0]        req_action_r;
  logic [2:0]        req_slot_r;
  logic              req_slot_ok_r;
  logic signed [9:0] req_col_r, req_row_r;
  logic [7:0]        req_width_r, req_height_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] free_slot_r, free_slot_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt;
  logic          closed_r, closed_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [2:0]    out_result_slot_r;
  logic          out_was_closed_r;
  logic          out_focus_valid_r;
  logic [2:0]    out_focus_slot_r;
  logic [3:0]    out_open_count_r;

  logic [MAX_WINDOWS-1:0] cell_valid;
  logic [SW-1:0]          cell_slot  [MAX_WINDOWS];
  rect_t                  cell_rect  [MAX_WINDOWS];
  cell_flags_t            cell_flags [MAX_WINDOWS];
  cell_ctrl_t             cell_ctrl  [MAX_WINDOWS];
  logic [SW-1:0]          ld_slot;
  rect_t                  ld_rect;

  // ---------------- sequencer ----------------
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_REPORT;
      ST_REPORT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    eval_en   = 1'b0;
    apply_en  = 1'b0;
    report_en = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_EVAL:   eval_en   = 1'b1;
      ST_APPLY:  apply_en  = 1'b1;
      ST_REPORT: report_en = out_free;
      default:   in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action_r  <= in_action;
      req_slot_r    <= in_slot;
      req_slot_ok_r <= 32'(in_slot) < MAX_WINDOWS;
      req_col_r     <= in_pos_col;
      req_row_r     <= in_pos_row;
      req_width_r   <= in_width;
      req_height_r  <= in_height;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    logic          up_valid;
    logic [SW-1:0] up_slot;
    rect_t         up_rect;

    if (i == MAX_WINDOWS - 1) begin : g_last
      assign up_valid = 1'b0;
      assign up_slot  = '0;
      assign up_rect  = '0;
    end else begin : g_mid
      assign up_valid = cell_valid[i+1];
      assign up_slot  = cell_slot[i+1];
      assign up_rect  = cell_rect[i+1];
    end

    wst_cell #(
      .SLOT_W (SW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (cell_ctrl[i]),
      .q_slot_i   (SW'(req_slot_r)),
      .q_col_i    (req_col_r),
      .q_row_i    (req_row_r),
      .up_valid_i (up_valid),
      .up_slot_i  (up_slot),
      .up_rect_i  (up_rect),
      .ld_slot_i  (ld_slot),
      .ld_rect_i  (ld_rect),
      .valid_o    (cell_valid[i]),
      .slot_o     (cell_slot[i]),
      .rect_o     (cell_rect[i]),
      .flags_o    (cell_flags[i])
    );
  end

  // lowest slot not held by any listed cell
  always_comb begin
    logic [MAX_WINDOWS-1:0] active;
    active        = '0;
    free_slot_nxt = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      for (int j = 0; j < MAX_WINDOWS; j++) begin
        if (cell_valid[i] && (cell_slot[i] == SW'(j))) active[j] = 1'b1;
      end
    end
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (!active[i]) free_slot_nxt = SW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en) free_slot_r <= free_slot_nxt;
  end

  // ---------------- apply step ----------------
  always_comb begin
    logic [MAX_WINDOWS-1:0] sel, ge;
    logic                   taken, run, found, sel_close;
    logic                   is_slot_op, is_point_op;
    logic                   do_create, do_close, do_raise;
    logic [SW-1:0]          carry_slot;
    rect_t                  carry_rect;

    is_slot_op  = (req_action_r == ACT_CLOSE) || (req_action_r == ACT_RAISE);
    is_point_op = (req_action_r == ACT_CLICK) || (req_action_r == ACT_HIT);

    // topmost hit wins: walk down from the top of the list
    taken = 1'b0;
    sel   = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (is_slot_op) begin
        sel[i] = cell_flags[i].match && req_slot_ok_r;
      end else if (is_point_op) begin
        sel[i] = cell_flags[i].hit && !taken;
      end
      taken = taken || cell_flags[i].hit;
    end

    found      = |sel;
    sel_close  = 1'b0;
    carry_slot = '0;
    carry_rect = '0;
    run        = 1'b0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (sel[i]) begin
        carry_slot = carry_slot | cell_slot[i];
        carry_rect = carry_rect | cell_rect[i];
        sel_close  = sel_close | cell_flags[i].close_hit;
      end
      run   = run || sel[i];
      ge[i] = run;
    end

    do_create = (req_action_r == ACT_CREATE) && (count_r < CNT_MAX);
    do_close  = found && ((req_action_r == ACT_CLOSE) ||
                          ((req_action_r == ACT_CLICK) && sel_close));
    do_raise  = found && ((req_action_r == ACT_RAISE) ||
                          ((req_action_r == ACT_CLICK) && !sel_close));

    ld_slot = do_create ? free_slot_r : carry_slot;
    ld_rect = do_create ? rect_t'{req_col_r, req_row_r, req_width_r, req_height_r}
                        : carry_rect;

    // close shifts everything from the gap upward; raise rotates the selected entry to the top
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      cell_ctrl[i].eval = eval_en;
      cell_ctrl[i].op   = OP_HOLD;
      if (apply_en) begin
        if (do_create && (count_r == CW'(i))) begin
          cell_ctrl[i].op = OP_LOAD;
        end else if (do_close && ge[i]) begin
          cell_ctrl[i].op = OP_SHIFT;
        end else if (do_raise) begin
          if (count_r == CW'(i + 1)) begin
            cell_ctrl[i].op = OP_LOAD;
          end else if (ge[i]) begin
            cell_ctrl[i].op = OP_SHIFT;
          end
        end
      end
    end

    count_nxt = count_r;
    if (apply_en && do_create) count_nxt = count_r + CW'(1);
    if (apply_en && do_close)  count_nxt = count_r - CW'(1);

    status_nxt = STAT_OK;
    rslot_nxt  = '0;
    closed_nxt = 1'b0;
    case (req_action_r)
      ACT_CREATE: begin
        if (do_create) rslot_nxt = free_slot_r;
        else status_nxt = STAT_FULL;
      end
      ACT_CLOSE, ACT_RAISE: begin
        if (found) rslot_nxt = carry_slot;
        else status_nxt = STAT_BAD_SLOT;
      end
      ACT_CLICK, ACT_HIT: begin
        if (found) begin
          rslot_nxt  = carry_slot;
          closed_nxt = (req_action_r == ACT_CLICK) && sel_close;
        end else begin
          status_nxt = STAT_MISS;
        end
      end
      default: status_nxt = STAT_BAD_SLOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      status_r <= status_nxt;
      rslot_r  <= rslot_nxt;
      closed_r <= closed_nxt;
    end
  end

  // ---------------- report step ----------------
  logic [MAX_WINDOWS-1:0] valid_above, is_top;
  logic [SW-1:0]          focus_slot;

  assign valid_above = {1'b0, cell_valid[MAX_WINDOWS-1:1]};
  assign is_top      = cell_valid & ~valid_above;

  always_comb begin
    focus_slot = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (is_top[i]) focus_slot = focus_slot | cell_slot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= report_en || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (report_en) begin
      out_status_r      <= status_r;
      out_result_slot_r <= 3'(rslot_r);
      out_was_closed_r  <= closed_r;
      out_focus_valid_r <= count_r != '0;
      out_focus_slot_r  <= 3'(focus_slot);
      out_open_count_r  <= 4'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_result_slot_r;
  assign out_was_closed  = out_was_closed_r;
  assign out_focus_valid = out_focus_valid_r;
  assign out_focus_slot  = out_focus_slot_r;
  assign out_open_count  = out_open_count_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("open count beyond table size");

  a_list_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(count_r))
    else $error("listed cells disagree with open count");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("accepted beat did not start evaluation");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_REPORT))
    else $error("result beat raised outside report step");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/wst_cell.sv
// one stacking list position: slot number, rectangle and registered hit flags
`timescale 1ns / 1ps
`default_nettype none

module wst_cell #(
  parameter int SLOT_W = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wst_pkg::cell_ctrl_t       ctrl_i,
  input  logic [SLOT_W-1:0]         q_slot_i,
  input  logic signed [9:0]         q_col_i,
  input  logic signed [9:0]         q_row_i,
  input  logic                      up_valid_i,
  input  logic [SLOT_W-1:0]         up_slot_i,
  input  wst_pkg::rect_t            up_rect_i,
  input  logic [SLOT_W-1:0]         ld_slot_i,
  input  wst_pkg::rect_t            ld_rect_i,
  output logic                      valid_o,
  output logic [SLOT_W-1:0]         slot_o,
  output wst_pkg::rect_t            rect_o,
  output wst_pkg::cell_flags_t      flags_o
);
  import wst_pkg::*;

  logic              valid_r, valid_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  rect_t             rect_r, rect_nxt;
  cell_flags_t       flags_r, flags_nxt;

  logic signed [11:0] col_x, row_x, left_x, top_x, right_x, bottom_x;
  logic               in_rect, on_close;

  always_comb begin
    col_x    = 12'(q_col_i);
    row_x    = 12'(q_row_i);
    left_x   = 12'(rect_r.left);
    top_x    = 12'(rect_r.top);
    right_x  = left_x + $signed({4'b0000, rect_r.width});
    bottom_x = top_x + $signed({4'b0000, rect_r.height});
    // zero width or height never holds a point
    in_rect  = (col_x >= left_x) && (col_x < right_x) &&
               (row_x >= top_x) && (row_x < bottom_x);
    on_close = (rect_r.width >= CLOSE_MIN_WIDTH) && (q_row_i == rect_r.top) &&
               (col_x >= right_x - CLOSE_LO_OFS) && (col_x <= right_x - CLOSE_HI_OFS);
  end

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    rect_nxt  = rect_r;
    case (ctrl_i.op)
      OP_SHIFT: begin
        valid_nxt = up_valid_i;
        slot_nxt  = up_slot_i;
        rect_nxt  = up_rect_i;
      end
      OP_LOAD: begin
        valid_nxt = 1'b1;
        slot_nxt  = ld_slot_i;
        rect_nxt  = ld_rect_i;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_comb begin
    flags_nxt = flags_r;
    if (ctrl_i.eval) begin
      flags_nxt.match     = valid_r && (slot_r == q_slot_i);
      flags_nxt.hit       = valid_r && in_rect;
      flags_nxt.close_hit = valid_r && in_rect && on_close;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    rect_r <= rect_nxt;
  end

  assign valid_o = valid_r;
  assign slot_o  = slot_r;
  assign rect_o  = rect_r;
  assign flags_o = flags_r;

endmodule

`default_nettype wire
